// File: sv/skf_pkg.sv
package skf_pkg;

    // Datapath widths
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int GAIN_W = 17;
    localparam int PROD_W = GAIN_W + DATA_W + 1;
    localparam int IDX_W  = 2;
    localparam int PC_W   = 4;
    localparam int CNT_W  = 5;

    // Fixed-point constants
    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << FRAC_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    // Register reset values
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd655;
    localparam logic [DATA_W-1:0] MEAS_NOISE_RST    = 32'd65536;
    localparam logic [DATA_W-1:0] INIT_COV_RST      = 32'd65536;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_INIT_COV      = 2'd2;

    // Divider: one unshifted step, then FRAC_W shift-subtract steps
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(FRAC_W);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(1);

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_PRED,
        OP_DEN,
        OP_DIV0,
        OP_DIVN,
        OP_MULE,
        OP_UPDE,
        OP_MULP,
        OP_UPDP,
        OP_ZERO,
        OP_OUT
    } op_t;

    // Sequencer conditions
    typedef enum logic [2:0] {
        C_SEQ,
        C_WAIT_IN,
        C_JMP_DENZ,
        C_JMP_LOOP,
        C_WAIT_OUT,
        C_JMP
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Program addresses
    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_DIVN  = 4'd4;
    localparam logic [PC_W-1:0] PC_ZERO  = 4'd9;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd10;

    // Microcode program
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:    w = '{op: OP_LOAD, cond: C_WAIT_IN,  target: PC_START};
            4'd1:    w = '{op: OP_PRED, cond: C_SEQ,      target: PC_START};
            4'd2:    w = '{op: OP_DEN,  cond: C_JMP_DENZ, target: PC_ZERO};
            4'd3:    w = '{op: OP_DIV0, cond: C_SEQ,      target: PC_START};
            4'd4:    w = '{op: OP_DIVN, cond: C_JMP_LOOP, target: PC_DIVN};
            4'd5:    w = '{op: OP_MULE, cond: C_SEQ,      target: PC_START};
            4'd6:    w = '{op: OP_UPDE, cond: C_SEQ,      target: PC_START};
            4'd7:    w = '{op: OP_MULP, cond: C_SEQ,      target: PC_START};
            4'd8:    w = '{op: OP_UPDP, cond: C_JMP,      target: PC_OUT};
            4'd9:    w = '{op: OP_ZERO, cond: C_SEQ,      target: PC_START};
            4'd10:   w = '{op: OP_OUT,  cond: C_WAIT_OUT, target: PC_START};
            default: w = '{op: OP_NOP,  cond: C_JMP,      target: PC_START};
        endcase
        return w;
    endfunction

endpackage

// File: sv/scalar_kalman_filter.sv
// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------
// in        in_valid / in_stall       measurement (signed Q16.16)
// out       out_valid / out_stall     estimate (signed Q16.16), gain (Q1.16)
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A measurement is taken only at the first program step, so the next one waits
// until the whole program has run; the 17-step restoring divide is most of it.
// With a zero denominator the divide and the updates are skipped.
// Reset clears the estimate and loads the covariance and registers with defaults.
// The result waits in an output register while the next item is taken; the
// sequencer holds at its last step only while an earlier result is still stalled.
module scalar_kalman_filter
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [skf_pkg::DATA_W-1:0] measurement,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [skf_pkg::DATA_W-1:0] estimate,
    output logic [skf_pkg::GAIN_W-1:0]  gain,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [skf_pkg::IDX_W-1:0]   cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]  cfg_data
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int GW = skf_pkg::GAIN_W;
    localparam int FW = skf_pkg::FRAC_W;
    localparam int PW = skf_pkg::PROD_W;

    // Control state
    logic [skf_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [skf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    // Configuration and filter state
    logic [DW-1:0]        q_noise_reg, q_noise_next;
    logic [DW-1:0]        r_noise_reg, r_noise_next;
    logic [DW-1:0]        init_cov_reg, init_cov_next;
    logic signed [DW-1:0] est_reg, est_next;
    logic [DW-1:0]        cov_reg, cov_next;

    // Working registers
    logic signed [DW-1:0] meas_reg, meas_next;
    logic [DW-1:0]        pp_reg, pp_next;
    logic [DW:0]          den_reg, den_next;
    logic [DW+1:0]        rem_reg, rem_next;
    logic [GW-1:0]        quo_reg, quo_next;
    logic signed [DW:0]   err_reg, err_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [DW-1:0] estimate_reg, estimate_next;
    logic [GW-1:0]        gain_reg, gain_next;

    // Datapath nets
    skf_pkg::uword_t      uw;
    logic                 in_accept;
    logic                 out_busy;
    logic                 hold;
    logic                 jump;
    logic [DW:0]          pred_sum;
    logic [DW:0]          den_sum;
    logic [DW+1:0]        div_sh;
    logic                 div_ge;
    logic [DW+1:0]        div_diff;
    logic signed [GW:0]   mul_a;
    logic signed [DW+1:0] mul_b;
    logic signed [GW+DW+1:0] mul_full;
    logic signed [PW-1:0] prod_rnd;

    assign uw        = skf_pkg::ucode_rom(pc_reg);
    assign in_stall  = (pc_reg != skf_pkg::PC_START);
    assign in_accept = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign gain      = gain_reg;

    // Covariance prediction and gain denominator
    assign pred_sum = {1'b0, cov_reg} + {1'b0, q_noise_reg};
    assign den_sum  = {1'b0, pp_reg} + {1'b0, r_noise_reg};

    // Restoring divide step; the first step compares without a shift
    assign div_sh   = (uw.op == skf_pkg::OP_DIVN) ? {rem_reg[DW:0], 1'b0} : rem_reg;
    assign div_ge   = (div_sh >= {1'b0, den_reg});
    assign div_diff = div_sh - {1'b0, den_reg};

    // Shared multiplier: gain times error, or (one - gain) times covariance
    assign mul_a    = (uw.op == skf_pkg::OP_MULE) ? {1'b0, quo_reg}
                                                  : {1'b0, skf_pkg::GAIN_ONE - quo_reg};
    assign mul_b    = (uw.op == skf_pkg::OP_MULE) ? {err_reg[DW], err_reg}
                                                  : {2'b00, pp_reg};
    assign mul_full = (GW+DW+2)'(mul_a) * (GW+DW+2)'(mul_b);
    assign prod_rnd = prod_reg + skf_pkg::ROUND_HALF;

    // Sequencer and datapath
    always_comb
    begin
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_busy;
        q_noise_next   = q_noise_reg;
        r_noise_next   = r_noise_reg;
        init_cov_next  = init_cov_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        meas_next      = meas_reg;
        pp_next        = pp_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        estimate_next  = estimate_reg;
        gain_next      = gain_reg;
        hold           = 1'b0;
        jump           = 1'b0;

        // Next program step
        case (uw.cond)
            skf_pkg::C_WAIT_IN:  hold = !in_accept;
            skf_pkg::C_JMP_DENZ: jump = (den_sum == '0);
            skf_pkg::C_JMP_LOOP: jump = (cnt_reg != skf_pkg::DIV_LAST);
            skf_pkg::C_WAIT_OUT:
            begin
                hold = out_busy;
                jump = 1'b1;
            end
            skf_pkg::C_JMP:      jump = 1'b1;
            default:             jump = 1'b0;
        endcase

        if (hold)
            pc_next = pc_reg;
        else if (jump)
            pc_next = uw.target;
        else
            pc_next = pc_reg + skf_pkg::PC_W'(1);

        // Datapath operation of this step
        if (!hold)
        begin
            case (uw.op)
                skf_pkg::OP_LOAD: meas_next = measurement;
                skf_pkg::OP_PRED: pp_next = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
                skf_pkg::OP_DEN:
                begin
                    den_next = den_sum;
                    rem_next = {2'b00, pp_reg};
                    quo_next = '0;
                    cnt_next = skf_pkg::DIV_STEPS;
                    err_next = {meas_reg[DW-1], meas_reg} - {est_reg[DW-1], est_reg};
                end
                skf_pkg::OP_DIV0:
                begin
                    rem_next = div_ge ? div_diff : div_sh;
                    quo_next = {quo_reg[GW-2:0], div_ge};
                end
                skf_pkg::OP_DIVN:
                begin
                    rem_next = div_ge ? div_diff : div_sh;
                    quo_next = {quo_reg[GW-2:0], div_ge};
                    cnt_next = cnt_reg - skf_pkg::CNT_W'(1);
                end
                skf_pkg::OP_MULE: prod_next = mul_full[PW-1:0];
                skf_pkg::OP_UPDE: est_next = est_reg + prod_rnd[DW+FW-1:FW];
                skf_pkg::OP_MULP: prod_next = mul_full[PW-1:0];
                skf_pkg::OP_UPDP: cov_next = prod_reg[DW+FW-1:FW];
                skf_pkg::OP_ZERO:
                begin
                    quo_next = '0;
                    cov_next = pp_reg;
                end
                skf_pkg::OP_OUT:
                begin
                    out_valid_next = 1'b1;
                    estimate_next  = est_reg;
                    gain_next      = quo_reg;
                end
                default: ;
            endcase
        end

        // Register writes; an unknown index is ignored
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                skf_pkg::REG_PROCESS_NOISE: q_noise_next = cfg_data;
                skf_pkg::REG_MEAS_NOISE:    r_noise_next = cfg_data;
                skf_pkg::REG_INIT_COV:
                begin
                    init_cov_next = cfg_data;
                    cov_next      = cfg_data;
                end
                default: ;
            endcase
        end
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= skf_pkg::PC_START;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            q_noise_reg   <= skf_pkg::PROCESS_NOISE_RST;
            r_noise_reg   <= skf_pkg::MEAS_NOISE_RST;
            init_cov_reg  <= skf_pkg::INIT_COV_RST;
            est_reg       <= '0;
            cov_reg       <= skf_pkg::INIT_COV_RST;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            q_noise_reg   <= q_noise_next;
            r_noise_reg   <= r_noise_next;
            init_cov_reg  <= init_cov_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        pp_reg       <= pp_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        err_reg      <= err_next;
        prod_reg     <= prod_next;
        estimate_reg <= estimate_next;
        gain_reg     <= gain_next;
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    // Index with no register behind it; writes to it must be dropped
    localparam logic [skf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int ITEMS_TOTAL     = 1450;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int END_WAIT_CYCLES = 40;

    localparam logic signed [skf_pkg::DATA_W-1:0] MEAS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [skf_pkg::DATA_W-1:0] MEAS_MIN = 32'sh8000_0000;
    localparam logic [skf_pkg::DATA_W-1:0]        COV_MAX  = 32'hFFFF_FFFF;
    localparam longint                            EST_MAX  = 64'sd2147483647;
    localparam longint                            EST_MIN  = -EST_MAX - 1;

    typedef struct {
        logic signed [skf_pkg::DATA_W-1:0] est;
        logic [skf_pkg::GAIN_W-1:0]        gain;
    } kf_result_t;

    logic                              clk;
    logic                              rst_n       = 1'b0;
    logic                              in_valid    = 1'b0;
    logic                              in_stall;
    logic signed [skf_pkg::DATA_W-1:0] measurement = '0;
    logic                              out_valid;
    logic                              out_stall   = 1'b0;
    logic signed [skf_pkg::DATA_W-1:0] estimate;
    logic [skf_pkg::GAIN_W-1:0]        gain;
    logic                              cfg_valid   = 1'b0;
    logic                              cfg_ready;
    logic [skf_pkg::IDX_W-1:0]         cfg_index   = '0;
    logic [skf_pkg::DATA_W-1:0]        cfg_data    = '0;

    // Filter state and settings as the block should hold them
    logic [skf_pkg::DATA_W-1:0]        q_reg;
    logic [skf_pkg::DATA_W-1:0]        r_reg;
    logic [skf_pkg::DATA_W-1:0]        p0_reg;
    logic signed [skf_pkg::DATA_W-1:0] est_state;
    logic [skf_pkg::DATA_W-1:0]        cov_state;

    kf_result_t pending_results[$];

    // Traffic shaping switches, changed per phase
    bit in_gaps_on = 1'b1;
    bit stall_on   = 1'b1;

    int n_items     = 0;
    int n_results   = 0;
    int n_writes    = 0;
    int n_phases    = 0;
    int n_zero_gain = 0;
    int n_fail      = 0;
    int idle_cycles = 0;

    scalar_kalman_filter dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .gain        (gain),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One filter step: predict covariance, gain, estimate and covariance update
    task automatic kalman_update(input logic signed [skf_pkg::DATA_W-1:0] meas);
        longint unsigned pp;
        longint unsigned den;
        longint unsigned g;
        longint          err;
        longint          adj;
        longint          nxt;
        kf_result_t      res;
        g   = 0;
        pp  = 64'(cov_state) + 64'(q_reg);
        if (pp > 64'(COV_MAX))
        begin
            pp = 64'(COV_MAX);
        end
        den = pp + 64'(r_reg);
        nxt = longint'(est_state);
        if (den != 0)
        begin
            g = (pp << skf_pkg::FRAC_W) / den;
            if (g > 64'(skf_pkg::GAIN_ONE))
            begin
                g = 64'(skf_pkg::GAIN_ONE);
            end
            err = longint'(meas) - longint'(est_state);
            // round to nearest, ties up; >>> floors negative values
            adj = (longint'(g) * err + 64'sd32768) >>> skf_pkg::FRAC_W;
            nxt = nxt + adj;
            if (nxt > EST_MAX)
            begin
                nxt = EST_MAX;
            end
            if (nxt < EST_MIN)
            begin
                nxt = EST_MIN;
            end
            pp = ((64'(skf_pkg::GAIN_ONE) - g) * pp) >> skf_pkg::FRAC_W;
        end
        est_state = nxt[skf_pkg::DATA_W-1:0];
        cov_state = pp[skf_pkg::DATA_W-1:0];
        res.est   = est_state;
        res.gain  = g[skf_pkg::GAIN_W-1:0];
        pending_results.push_back(res);
        if (g == 0)
        begin
            n_zero_gain++;
        end
    endtask

    // Sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!in_gaps_on || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(1, 4);
        end
        if (r < 95)
        begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(30, 80);
    endfunction

    // Half of the picks are a sensor reading scattered around the current estimate
    function automatic logic signed [skf_pkg::DATA_W-1:0] pick_measurement();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return est_state + skf_pkg::DATA_W'($urandom_range(0, 1 << 18)) - 32'sd131072;
        end
        if (r < 8)
        begin
            return $urandom;
        end
        if (r == 8)
        begin
            case ($urandom_range(0, 3))
                0:       return MEAS_MAX;
                1:       return MEAS_MIN;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        return skf_pkg::DATA_W'($urandom_range(0, 131071)) - 32'sd65536;
    endfunction

    function automatic logic [skf_pkg::DATA_W-1:0] pick_setting();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COV_MAX;
            2:       return $urandom;
            3:       return $urandom_range(0, 1 << 16);
            4:       return $urandom_range(0, 1 << 20);
            5:       return skf_pkg::MEAS_NOISE_RST;
            6:       return 32'd1;
            default: return $urandom_range(1 << 16, 1 << 24);
        endcase
    endfunction

    // Hand one measurement to the block; valid stays up when no gap follows
    task automatic send_measurement(input logic signed [skf_pkg::DATA_W-1:0] m);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= m;
        do @(posedge clk); while (in_stall);
        kalman_update(m);
        n_items++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [skf_pkg::IDX_W-1:0] idx,
                             input logic [skf_pkg::DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            skf_pkg::REG_PROCESS_NOISE: q_reg = val;
            skf_pkg::REG_MEAS_NOISE:    r_reg = val;
            skf_pkg::REG_INIT_COV:
            begin
                p0_reg    = val;
                cov_state = val;
            end
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_measurement('0);
        send_measurement(MEAS_MAX);
        send_measurement(MEAS_MIN);
        send_measurement(MEAS_MAX);
        send_measurement(-32'sd1);
        send_measurement(32'sd1);
        send_measurement(32'sh0001_0000);
        drain();
    endtask

    // P + R of zero: gain 0, estimate held, covariance stays 0
    task automatic test_zero_denominator();
        write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
        write_reg(skf_pkg::REG_MEAS_NOISE, '0);
        write_reg(skf_pkg::REG_INIT_COV, '0);
        send_measurement(MEAS_MAX);
        send_measurement(MEAS_MIN);
        send_measurement($urandom);
        drain();
        // smallest nonzero denominator gives full gain
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'd1);
        send_measurement($urandom);
        drain();
    endtask

    // P + Q clips at all ones
    task automatic test_covariance_saturation();
        write_reg(skf_pkg::REG_MEAS_NOISE, COV_MAX);
        write_reg(skf_pkg::REG_PROCESS_NOISE, COV_MAX);
        write_reg(skf_pkg::REG_INIT_COV, COV_MAX);
        send_measurement(MEAS_MIN);
        send_measurement(MEAS_MAX);
        send_measurement('0);
        drain();
        write_reg(skf_pkg::REG_MEAS_NOISE, '0);
        send_measurement(MEAS_MIN);
        send_measurement(MEAS_MAX);
        drain();
    endtask

    // Unused index is dropped; covariance write takes effect at once
    task automatic test_register_writes();
        write_reg(REG_UNUSED, $urandom);
        send_measurement($urandom);
        drain();
        write_reg(skf_pkg::REG_MEAS_NOISE, skf_pkg::MEAS_NOISE_RST);
        write_reg(skf_pkg::REG_PROCESS_NOISE, skf_pkg::PROCESS_NOISE_RST);
        write_reg(skf_pkg::REG_INIT_COV, 32'd1);
        send_measurement(32'sh0004_0000);
        drain();
    endtask

    task automatic test_random_settings();
        int n;
        while (n_items < ITEMS_TOTAL)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, pick_setting());
            end
            if ($urandom_range(0, 2) != 0)
            begin
                write_reg(skf_pkg::REG_MEAS_NOISE, pick_setting());
            end
            if ($urandom_range(0, 2) != 0)
            begin
                write_reg(skf_pkg::REG_INIT_COV, pick_setting());
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_UNUSED, $urandom);
            end
            in_gaps_on = ($urandom_range(0, 3) != 0);
            stall_on   = ($urandom_range(0, 3) != 0);
            n = $urandom_range(40, 120);
            repeat (n) send_measurement(pick_measurement());
            drain();
            n_phases++;
        end
    endtask

    // Receiver back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (pick_stall_len()) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        kf_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: estimate %0d gain %0d", estimate, gain);
                n_fail++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_results++;
                if (estimate !== want.est)
                begin
                    $error("estimate mismatch: expected %0d, actual %0d", want.est, estimate);
                    n_fail++;
                end
                if (gain !== want.gain)
                begin
                    $error("gain mismatch: expected %0d, actual %0d", want.gain, gain);
                    n_fail++;
                end
            end
        end
    end

    // Hang detection: no handshake of any kind for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("timeout: %0d results still pending", pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        q_reg     = skf_pkg::PROCESS_NOISE_RST;
        r_reg     = skf_pkg::MEAS_NOISE_RST;
        p0_reg    = skf_pkg::INIT_COV_RST;
        est_state = '0;
        cov_state = skf_pkg::INIT_COV_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_denominator();
        test_covariance_saturation();
        test_register_writes();
        test_random_settings();

        drain();
        repeat (END_WAIT_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            n_fail++;
        end
        $display("%0d measurements over %0d random settings, %0d register writes",
                 n_items, n_phases, n_writes);
        $display("%0d results checked, %0d of them with zero gain", n_results, n_zero_gain);
        if (n_fail == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
